>>> rtl/fsms_pkg.sv
// Package for the fuzzy substring match score unit: payload and control structs,
// item kind and status codes, and the ASCII lowercase helper. No dependencies.
`default_nettype none

package fsms_pkg;

    localparam int MAX_LEN_DEF = 16;

    localparam logic [1:0] KIND_CAND   = 2'd0;
    localparam logic [1:0] KIND_KEY    = 2'd1;
    localparam logic [1:0] KIND_FINISH = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam logic [1:0] ST_SCORED   = 2'd0;
    localparam logic [1:0] ST_TOO_LONG = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_EXACT    = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] char_byte;
    } t_in_item;

    typedef struct packed {
        logic [31:0] score;
        logic [1:0]  status;
    } t_out_item;

    typedef struct packed {
        logic       load_cand;
        logic       load_key;
        logic       eq_init;
        logic       score_init;
        logic       i_next;
        logic       j_init;
        logic       j_next;
        logic       t_init;
        logic       t_next;
        logic       ext_init;
        logic       ext_next;
        logic       commit;
        logic       addr_ext;
        logic       out_load;
        logic [1:0] out_status;
    } t_cmd;

    typedef struct packed {
        logic too_long;
        logic empty;
        logic len_eq;
        logic data_eq;
        logic t_last_win;
        logic t_last_len;
        logic i_ok;
        logic j_ok;
        logic ext_ok;
        logic out_free;
    } t_sts;

    function automatic logic [7:0] lower_ascii(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A) begin
            return c + 8'h20;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/fsms_ram.sv
// Generic single write port RAM with one registered read port.
// No dependencies.
`default_nettype none

module fsms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> rtl/fsms_ctrl.sv
// Sequencer for the match score unit: input handshake, finish checks and the
// window search loop. Uses fsms_pkg; drives fsms_dp through t_cmd.
`default_nettype none

module fsms_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire fsms_pkg::t_in_item i_item,
    output logic                   o_ready,
    input  wire fsms_pkg::t_sts    i_sts,
    output fsms_pkg::t_cmd         o_cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_FIN      = 4'd1;
    localparam logic [3:0] S_EQ_ADDR  = 4'd2;
    localparam logic [3:0] S_EQ_DATA  = 4'd3;
    localparam logic [3:0] S_I_CHECK  = 4'd4;
    localparam logic [3:0] S_J_CHECK  = 4'd5;
    localparam logic [3:0] S_CMP_ADDR = 4'd6;
    localparam logic [3:0] S_CMP_DATA = 4'd7;
    localparam logic [3:0] S_EXT_CHK  = 4'd8;
    localparam logic [3:0] S_EXT_DATA = 4'd9;
    localparam logic [3:0] S_DONE     = 4'd10;

    logic [3:0] r_state, n_state;
    logic [1:0] r_code, n_code;
    logic       take;

    assign o_ready = (r_state == S_IDLE);
    assign take    = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        o_cmd   = '0;
        o_cmd.out_status = r_code;
        unique case (r_state)
            S_IDLE: begin
                if (take) begin
                    o_cmd.load_cand = (i_item.kind == fsms_pkg::KIND_CAND);
                    o_cmd.load_key  = (i_item.kind == fsms_pkg::KIND_KEY);
                    if (i_item.kind == fsms_pkg::KIND_FINISH) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_FIN: begin
                if (i_sts.too_long) begin
                    n_code  = fsms_pkg::ST_TOO_LONG;
                    n_state = S_DONE;
                end else if (i_sts.empty) begin
                    n_code  = fsms_pkg::ST_EMPTY;
                    n_state = S_DONE;
                end else if (i_sts.len_eq) begin
                    o_cmd.eq_init = 1'b1;
                    n_state = S_EQ_ADDR;
                end else begin
                    o_cmd.score_init = 1'b1;
                    n_state = S_I_CHECK;
                end
            end
            S_EQ_ADDR: begin
                n_state = S_EQ_DATA;
            end
            S_EQ_DATA: begin
                if (!i_sts.data_eq) begin
                    o_cmd.score_init = 1'b1;
                    n_state = S_I_CHECK;
                end else if (i_sts.t_last_len) begin
                    n_code  = fsms_pkg::ST_EXACT;
                    n_state = S_DONE;
                end else begin
                    o_cmd.t_next = 1'b1;
                    n_state = S_EQ_ADDR;
                end
            end
            S_I_CHECK: begin
                if (i_sts.i_ok) begin
                    o_cmd.j_init = 1'b1;
                    n_state = S_J_CHECK;
                end else begin
                    n_code  = fsms_pkg::ST_SCORED;
                    n_state = S_DONE;
                end
            end
            S_J_CHECK: begin
                if (i_sts.j_ok) begin
                    o_cmd.t_init = 1'b1;
                    n_state = S_CMP_ADDR;
                end else begin
                    o_cmd.i_next = 1'b1;
                    n_state = S_I_CHECK;
                end
            end
            S_CMP_ADDR: begin
                n_state = S_CMP_DATA;
            end
            S_CMP_DATA: begin
                if (!i_sts.data_eq) begin
                    o_cmd.j_next = 1'b1;
                    n_state = S_J_CHECK;
                end else if (i_sts.t_last_win) begin
                    o_cmd.ext_init = 1'b1;
                    n_state = S_EXT_CHK;
                end else begin
                    o_cmd.t_next = 1'b1;
                    n_state = S_CMP_ADDR;
                end
            end
            S_EXT_CHK: begin
                o_cmd.addr_ext = 1'b1;
                if (i_sts.ext_ok) begin
                    n_state = S_EXT_DATA;
                end else begin
                    o_cmd.commit = 1'b1;
                    n_state = S_I_CHECK;
                end
            end
            S_EXT_DATA: begin
                if (i_sts.data_eq) begin
                    o_cmd.ext_next = 1'b1;
                    n_state = S_EXT_CHK;
                end else begin
                    o_cmd.commit = 1'b1;
                    n_state = S_I_CHECK;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_code  <= fsms_pkg::ST_SCORED;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
        end
    end

    a_done_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && i_sts.out_free) |=> (r_state == S_IDLE))
        else $error("finish did not return to idle");
    a_exact_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EQ_DATA) |-> i_sts.len_eq)
        else $error("equality check with unequal lengths");
    a_fin_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |=> (r_state != S_FIN))
        else $error("finish check repeated");

endmodule

`default_nettype wire

>>> rtl/fsms_dp.sv
// Datapath of the match score unit: string stores, counts, loop indices,
// mask and offset sum, output register. Uses fsms_pkg and fsms_ram.
`default_nettype none

module fsms_dp #(
    parameter int MAX_LEN = fsms_pkg::MAX_LEN_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire fsms_pkg::t_in_item i_item,
    input  wire fsms_pkg::t_cmd     i_cmd,
    output fsms_pkg::t_sts          o_sts,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output fsms_pkg::t_out_item     o_result
);

    localparam int CW = $clog2(MAX_LEN + 2);
    localparam int IW = CW + 1;
    localparam int AW = $clog2(MAX_LEN);

    logic [CW-1:0] r_cand_cnt, r_key_cnt;
    logic [IW-1:0] r_i, r_j, r_t, r_a, r_b;
    logic [CW-1:0] r_run;
    logic [31:0]   r_mask, r_sum;
    logic [CW-1:0] win;
    logic [IW-1:0] win_x, rl_x, kl_x, jt, it;
    logic [7:0]    lc, cand_rd, key_rd;
    logic          nz, we_cand, we_key;
    logic [AW-1:0] cand_ra, key_ra;
    logic [31:0]   sh_full, run_ones;
    logic [31:0]   out_score;

    assign lc = fsms_pkg::lower_ascii(i_item.char_byte);
    assign nz = (i_item.char_byte != 8'd0);
    assign we_cand = i_cmd.load_cand && nz && (32'(r_cand_cnt) < MAX_LEN);
    assign we_key  = i_cmd.load_key  && nz && (32'(r_key_cnt)  < MAX_LEN);

    assign rl_x  = IW'(r_cand_cnt);
    assign kl_x  = IW'(r_key_cnt);
    assign win   = (32'(r_cand_cnt) > 32'd12) ? CW'(3) : CW'(2);
    assign win_x = (IW'(win) > kl_x) ? kl_x : IW'(win);
    assign jt    = r_j + r_t;
    assign it    = r_i + r_t;

    assign key_ra  = i_cmd.addr_ext ? r_a[AW-1:0] : jt[AW-1:0];
    assign cand_ra = i_cmd.addr_ext ? r_b[AW-1:0] : it[AW-1:0];

    fsms_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_cand_ram (
        .i_clk  (i_clk),
        .i_we   (we_cand),
        .i_waddr(r_cand_cnt[AW-1:0]),
        .i_wdata(lc),
        .i_raddr(cand_ra),
        .o_rdata(cand_rd)
    );

    fsms_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_key_ram (
        .i_clk  (i_clk),
        .i_we   (we_key),
        .i_waddr(r_key_cnt[AW-1:0]),
        .i_wdata(lc),
        .i_raddr(key_ra),
        .o_rdata(key_rd)
    );

    always_comb begin
        o_sts.too_long   = (32'(r_cand_cnt) > MAX_LEN) || (32'(r_key_cnt) > MAX_LEN);
        o_sts.empty      = (r_cand_cnt == '0) || (r_key_cnt == '0);
        o_sts.len_eq     = (r_cand_cnt == r_key_cnt);
        o_sts.data_eq    = (cand_rd == key_rd);
        o_sts.t_last_win = ((r_t + IW'(1)) == win_x);
        o_sts.t_last_len = ((r_t + IW'(1)) == rl_x);
        o_sts.i_ok       = ((r_i + win_x) < rl_x);
        o_sts.j_ok       = ((r_j + win_x) <= kl_x);
        o_sts.ext_ok     = (r_a < kl_x) && (r_b < rl_x);
        o_sts.out_free   = !o_valid || i_ready;
    end

    assign sh_full  = 32'd32 - 32'(r_run);
    assign run_ones = (32'hFFFF_FFFF << sh_full[4:0]) >> 32'(r_i);

    always_comb begin
        case (i_cmd.out_status)
            fsms_pkg::ST_EXACT:  out_score = 32'hFFFF_FFFF;
            fsms_pkg::ST_SCORED: out_score = r_mask - r_sum;
            default:             out_score = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand_cnt <= '0;
            r_key_cnt  <= '0;
            o_valid    <= 1'b0;
        end else begin
            if (i_cmd.load_cand && nz) begin
                r_cand_cnt <= (32'(r_cand_cnt) < MAX_LEN) ? r_cand_cnt + CW'(1)
                                                          : CW'(MAX_LEN + 1);
            end
            if (i_cmd.load_key && nz) begin
                r_key_cnt <= (32'(r_key_cnt) < MAX_LEN) ? r_key_cnt + CW'(1)
                                                        : CW'(MAX_LEN + 1);
            end
            if (i_cmd.out_load) begin
                r_cand_cnt <= '0;
                r_key_cnt  <= '0;
                o_valid    <= 1'b1;
            end else if (i_ready) begin
                o_valid    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.eq_init) begin
            r_i <= '0;
            r_j <= '0;
            r_t <= '0;
        end
        if (i_cmd.score_init) begin
            r_i    <= '0;
            r_mask <= '0;
            r_sum  <= '0;
        end
        if (i_cmd.i_next) begin
            r_i <= r_i + IW'(1);
        end
        if (i_cmd.j_init) begin
            r_j <= '0;
        end
        if (i_cmd.j_next) begin
            r_j <= r_j + IW'(1);
        end
        if (i_cmd.t_init) begin
            r_t <= '0;
        end
        if (i_cmd.t_next) begin
            r_t <= r_t + IW'(1);
        end
        if (i_cmd.ext_init) begin
            r_a   <= r_j + win_x;
            r_b   <= r_i + win_x;
            r_run <= win_x[CW-1:0];
        end
        if (i_cmd.ext_next) begin
            r_a   <= r_a + IW'(1);
            r_b   <= r_b + IW'(1);
            r_run <= r_run + CW'(1);
        end
        if (i_cmd.commit) begin
            r_mask <= r_mask | run_ones;
            r_sum  <= r_sum + (32'd1 << 32'(r_j));
            r_i    <= r_i + IW'(r_run) + IW'(1);
        end
        if (i_cmd.out_load) begin
            o_result.score  <= out_score;
            o_result.status <= i_cmd.out_status;
        end
    end

    a_cand_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cand_cnt) <= MAX_LEN + 1)
        else $error("candidate count out of range");
    a_key_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_key_cnt) <= MAX_LEN + 1)
        else $error("key count out of range");
    a_out_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> (o_valid && r_cand_cnt == '0 && r_key_cnt == '0))
        else $error("result not posted or counts not cleared");
    a_run_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (IW'(r_run) >= win_x))
        else $error("run shorter than window");

endmodule

`default_nettype wire

>>> rtl/fuzzy_substring_match_score_unit.sv
// Candidate and key byte items are taken whenever the unit is idle. A finish item
// goes through accept, checks and post, with loop tests and byte compares in
// the equality pass, window search and run extension.
// One item at a time; a posted result waits in the output register while the
// next item is taken. Synchronous active-low reset clears counts and control.
// Top level of the match score unit; uses fsms_pkg, fsms_ctrl, fsms_dp.
`default_nettype none

module fuzzy_substring_match_score_unit #(
    parameter int MAX_LEN = fsms_pkg::MAX_LEN_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire fsms_pkg::t_in_item  i_item,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output fsms_pkg::t_out_item      o_result
);

    fsms_pkg::t_cmd cmd;
    fsms_pkg::t_sts sts;

    fsms_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .i_item (i_item),
        .o_ready(o_ready),
        .i_sts  (sts),
        .o_cmd  (cmd)
    );

    fsms_dp #(.MAX_LEN(MAX_LEN)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_result(o_result)
    );

endmodule

`default_nettype wire

>>> sim/fsms_checker.sv
// Checker for the fuzzy substring match score unit: watches both channels,
// predicts each finish result from the loaded strings and compares. Uses fsms_pkg.
`timescale 1ns / 100ps
`default_nettype none

module fsms_checker #(
    parameter int MAX_LEN = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire logic                i_ready_in,
    input  wire fsms_pkg::t_in_item  i_item,
    input  wire logic                i_valid_out,
    input  wire logic                i_ready_out,
    input  wire fsms_pkg::t_out_item i_result,
    output int                       o_fail_count,
    output int                       o_pending,
    output int                       o_score_count
);

    logic [7:0] cand_bytes [MAX_LEN];
    logic [7:0] key_bytes [MAX_LEN];
    int cand_len;
    int key_len;
    fsms_pkg::t_out_item expected_scores [$];

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    endfunction

    function automatic fsms_pkg::t_out_item score_strings();
        fsms_pkg::t_out_item r;
        int win, off, run, a, b, i, j, k;
        bit hit, same;
        logic [31:0] mask, total;
        r = '0;
        mask = '0;
        total = '0;
        if (cand_len > MAX_LEN || key_len > MAX_LEN) begin
            r.status = fsms_pkg::ST_TOO_LONG;
            return r;
        end
        if (cand_len == 0 || key_len == 0) begin
            r.status = fsms_pkg::ST_EMPTY;
            return r;
        end
        if (cand_len == key_len) begin
            same = 1;
            for (k = 0; k < cand_len; k++) begin
                if (cand_bytes[k] != key_bytes[k]) begin
                    same = 0;
                end
            end
            if (same) begin
                r.status = fsms_pkg::ST_EXACT;
                r.score = '1;
                return r;
            end
        end
        r.status = fsms_pkg::ST_SCORED;
        win = (cand_len > 12) ? 3 : 2;
        if (cand_len > 24) begin
            win++;
        end
        if (win > key_len) begin
            win = key_len;
        end
        for (i = 0; i + win < cand_len; i++) begin
            hit = 0;
            off = 0;
            for (j = 0; j + win <= key_len && !hit; j++) begin
                same = 1;
                for (k = 0; k < win; k++) begin
                    if (key_bytes[j + k] != cand_bytes[i + k]) begin
                        same = 0;
                    end
                end
                if (same) begin
                    hit = 1;
                    off = j;
                end
            end
            if (hit) begin
                run = win;
                a = off + win;
                b = i + win;
                while (a < key_len && b < cand_len && key_bytes[a] == cand_bytes[b]) begin
                    run++;
                    a++;
                    b++;
                end
                mask |= (32'hFFFF_FFFF << ((32 - run) & 31)) >> (i & 31);
                total += 32'd1 << (off & 31);
                i += run;
            end
        end
        r.score = mask - total;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cand_len <= 0;
            key_len <= 0;
            o_fail_count <= 0;
            o_score_count <= 0;
            expected_scores.delete();
        end else begin
            if (i_valid && i_ready_in) begin
                case (i_item.kind)
                    fsms_pkg::KIND_CAND: begin
                        if (i_item.char_byte != 0) begin
                            if (cand_len < MAX_LEN) begin
                                cand_bytes[cand_len] = to_lower(i_item.char_byte);
                                cand_len = cand_len + 1;
                            end else begin
                                cand_len = MAX_LEN + 1;
                            end
                        end
                    end
                    fsms_pkg::KIND_KEY: begin
                        if (i_item.char_byte != 0) begin
                            if (key_len < MAX_LEN) begin
                                key_bytes[key_len] = to_lower(i_item.char_byte);
                                key_len = key_len + 1;
                            end else begin
                                key_len = MAX_LEN + 1;
                            end
                        end
                    end
                    fsms_pkg::KIND_FINISH: begin
                        expected_scores.push_back(score_strings());
                        cand_len = 0;
                        key_len = 0;
                    end
                    default: ;
                endcase
            end
            if (i_valid_out && i_ready_out) begin
                o_score_count <= o_score_count + 1;
                if (expected_scores.size() == 0) begin
                    $display("%0t: unexpected transfer, actual score %h status %0d",
                             $time, i_result.score, i_result.status);
                    o_fail_count <= o_fail_count + 1;
                end else if (expected_scores[0] !== i_result) begin
                    $display("%0t: mismatch, expected score %h status %0d, actual score %h status %0d",
                             $time, expected_scores[0].score, expected_scores[0].status,
                             i_result.score, i_result.status);
                    o_fail_count <= o_fail_count + 1;
                    void'(expected_scores.pop_front());
                end else begin
                    void'(expected_scores.pop_front());
                end
            end
        end
    end

    assign o_pending = expected_scores.size();

endmodule

`default_nettype wire

>>> sim/fuzzy_substring_match_score_unit_test.sv
// Testbench top for the fuzzy substring match score unit: drives string pairs,
// throttles the result channel and gives the verdict. Uses fsms_pkg, fsms_checker.
`timescale 1ns / 100ps
`default_nettype none

module fuzzy_substring_match_score_unit_test;

    localparam int LIMIT = 3000000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    fsms_pkg::t_in_item in_item;
    logic out_valid;
    logic out_ready;
    fsms_pkg::t_out_item out_result;
    int fail_count;
    int pending;
    int score_count;
    int send_idle;
    int recv_idle;
    int hold_cycles;
    int cycle_count;
    int item_count;

    fuzzy_substring_match_score_unit uut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_ready(in_ready), .i_item(in_item),
        .o_valid(out_valid), .i_ready(out_ready), .o_result(out_result)
    );

    fsms_checker chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .i_ready_in(in_ready), .i_item(in_item),
        .i_valid_out(out_valid), .i_ready_out(out_ready), .i_result(out_result),
        .o_fail_count(fail_count), .o_pending(pending), .o_score_count(score_count)
    );

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // receiver: random stalls, with a long hold-off when requested
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic send(input logic [1:0] kind, input logic [7:0] c);
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= '{kind: kind, char_byte: c};
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
        item_count++;
    endtask

    function automatic logic [7:0] pick_char(input int alpha);
        case ($urandom_range(9))
            0: return 8'($urandom_range(255));
            1: return 8'($urandom_range(8'h41, 8'h41 + alpha - 1));
            default: return 8'($urandom_range(8'h61, 8'h61 + alpha - 1));
        endcase
    endfunction

    task automatic send_pair(input int clen, input int klen, input int alpha);
        logic [7:0] cand [$];
        int k, src;
        for (k = 0; k < clen; k++) begin
            cand.push_back(pick_char(alpha));
            send(fsms_pkg::KIND_CAND, cand[k]);
        end
        src = clen > 0 ? $urandom_range(clen - 1) : 0;
        for (k = 0; k < klen; k++) begin
            if (clen > 0 && $urandom_range(2) != 0) begin
                send(fsms_pkg::KIND_KEY, cand[(src + k) % clen]);
            end else begin
                send(fsms_pkg::KIND_KEY, pick_char(alpha));
            end
        end
        send(fsms_pkg::KIND_FINISH, 8'($urandom_range(255)));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) begin
            @(posedge clk);
        end
    endtask

    initial begin
        int phase, n, r, k;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        hold_cycles = 0;
        send_idle = 0;
        recv_idle = 0;
        item_count = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty, too long, case fold, zero byte, unused kind
        send(fsms_pkg::KIND_FINISH, 8'hFF);
        send(fsms_pkg::KIND_CAND, 8'h41);
        send(fsms_pkg::KIND_FINISH, 8'h00);
        send(fsms_pkg::KIND_CAND, 8'h5A);
        send(fsms_pkg::KIND_CAND, 8'h00);
        send(fsms_pkg::KIND_CAND, 8'h40);
        send(fsms_pkg::KIND_KEY, 8'h7A);
        send(fsms_pkg::KIND_KEY, 8'h5B);
        send(fsms_pkg::KIND_UNUSED, 8'h55);
        send(fsms_pkg::KIND_UNUSED, 8'hAA);
        send(fsms_pkg::KIND_KEY, 8'h40);
        send(fsms_pkg::KIND_FINISH, 8'h00);
        for (k = 0; k < 18; k++) begin
            send(fsms_pkg::KIND_CAND, 8'h80 + 8'(k));
        end
        send(fsms_pkg::KIND_KEY, 8'hFF);
        send(fsms_pkg::KIND_FINISH, 8'h00);
        send_pair(16, 16, 2);
        send_pair(16, 1, 2);
        send_pair(13, 4, 3);
        send_pair(3, 2, 2);
        drain();

        // long receiver hold-off while items keep coming
        hold_cycles = 400;
        for (k = 0; k < 6; k++) begin
            send_pair(2, 2, 2);
        end
        drain();

        for (phase = 0; phase < 3; phase++) begin
            send_idle = (phase == 0) ? 27 : (phase == 1) ? 73 : 0;
            recv_idle = (phase == 0) ? 73 : (phase == 1) ? 27 : 0;
            n = item_count + 540;
            while (item_count < n) begin
                r = $urandom_range(19);
                if (r == 0) begin
                    send(2'($urandom_range(3)), 8'($urandom_range(255)));
                end else if (r == 1) begin
                    send_pair($urandom_range(17, 20), $urandom_range(16), 4);
                end else if (r == 2) begin
                    send_pair($urandom_range(16), $urandom_range(17, 20), 4);
                end else if (r < 6) begin
                    send_pair($urandom_range(13, 16), $urandom_range(1, 16), 3);
                end else begin
                    send_pair($urandom_range(1, 12), $urandom_range(1, 8), 3);
                end
            end
            drain();
        end

        repeat (400) @(posedge clk);
        $display("Sent %0d items, checked %0d scores over short, long, empty,",
                 item_count, score_count);
        $display("overlong and exact pairs under three stall mixes.");
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> fuzzy_substring_match_score_unit.f
rtl/fsms_pkg.sv
rtl/fsms_ram.sv
rtl/fsms_ctrl.sv
rtl/fsms_dp.sv
rtl/fuzzy_substring_match_score_unit.sv
sim/fsms_checker.sv
sim/fuzzy_substring_match_score_unit_test.sv
